FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("assertion failed: invariant");

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/ptte_pkg.sv
// ----------------------------------------------------------------------------
// ptte_pkg
// constants, types and the root table of the preintegration table entry
// ----------------------------------------------------------------------------
package ptte_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int FIELD_IDX_W   = 10;
  localparam int CMP_W         = 14;
  localparam int COMP_W        = 17;
  localparam int DIV_W         = 33;
  localparam logic [COMP_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic REG_STEP_RATIO    = 1'b0;
  localparam logic REG_MIDPOINT_MODE = 1'b1;

  typedef struct packed {
    logic [COMP_W-1:0] opacity;
    logic [COMP_W-1:0] blue;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] red;
  } rgba_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] rem;
    res   = '0;
    rem   = n;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2^-(2^-k) in q30, each the floor square root of the one before
  function automatic logic [16:0][30:0] build_roots();
    logic [16:0][30:0] tab;
    logic [63:0]       v;
    tab[0] = 31'd1 << 29;
    for (int k = 1; k <= 16; k++) begin
      v      = isqrt64({33'd0, tab[k-1]} << 30);
      tab[k] = v[30:0];
    end
    return tab;
  endfunction

  localparam logic [16:0][30:0] ROOT_TAB = build_roots();

endpackage

FILE: hdl/ptte_ram.sv
// ----------------------------------------------------------------------------
// ptte_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ptte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/preintegration_table_entry_top.sv
// a load gives no result; each query gives one result in the output register
// throughput: one query at a time, set by the shared 32x32 multiplier that serves up to
//   16 log squarings, one exponent product, 16 root products and 4 blend products per entry
// reset: rst_n synchronous, active low; registers return to step_ratio 6554,
//   midpoint_mode 1; the entry store is not cleared and holds garbage until loaded
// ----------------------------------------------------------------------------
// preintegration_table_entry_top
// transfer-function store with an iterative preintegrated compositing engine
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module preintegration_table_entry_top (
  input  logic         clk,
  input  logic         rst_n,
  // input requests
  input  logic         in_tvalid,
  output logic         in_tready,
  // [9:0] entry_index, [26:10] red, [43:27] green, [60:44] blue,
  // [77:61] opacity, [87:78] front_index, [97:88] back_index
  input  logic [103:0] in_tdata,
  // [0] func
  input  logic         in_tuser,
  // results
  output logic         out_tvalid,
  input  logic         out_tready,
  // [16:0] out_red, [33:17] out_green, [50:34] out_blue, [67:51] out_opacity
  output logic [71:0]  out_tdata,
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [23:0]  cfg_data
);

  import ptte_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_FETCH0, S_FETCH0W, S_FETCHN, S_FETCHNW, S_LOG_INIT, S_LOG,
    S_PMUL, S_EXP, S_ROUND, S_ACC, S_CR, S_CG, S_CB, S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [23:0]       step_ratio_r, step_ratio_nxt;
  logic              midpoint_mode_r, midpoint_mode_nxt;
  logic [31:0]       f_r, f_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  d_r, d_nxt;
  logic [IDX_W-1:0]  m_r, m_nxt;
  logic [IDX_W-1:0]  bk_r, bk_nxt;
  logic              up_r, up_nxt;
  logic              eq_r, eq_nxt;
  rgba_t             cur_r, cur_nxt;
  rgba_t             smp_r, smp_nxt;
  logic [30:0]       x_r, x_nxt;
  logic [15:0]       frac_r, frac_nxt;
  logic [4:0]        e_r, e_nxt;
  logic [4:0]        q_r, q_nxt;
  logic [15:0]       r_r, r_nxt;
  logic [30:0]       y_r, y_nxt;
  logic [16:0]       a_r, a_nxt;
  logic [16:0]       acc_r, acc_nxt;
  logic [17:0]       cr_r, cr_nxt, cg_r, cg_nxt, cb_r, cb_nxt, ca_r, ca_nxt;
  logic              out_valid_r, out_valid_nxt;
  rgba_t             out_r, out_nxt;

  // input fields
  logic [FIELD_IDX_W-1:0] f_entry, f_front, f_back;
  rgba_t                  f_rgba, ld_rgba;
  logic                   in_acc;
  logic                   ld_ok;
  logic [IDX_W-1:0]       ld_addr, fr_cl, bk_cl, d_w;

  // ram
  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  rgba_t            ram_rdata;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // datapath helpers
  logic [16:0]      t_w;
  logic [4:0]       e_w;
  logic [31:0]      sq_w;
  logic [20:0]      nl_w;
  logic [53:0]      psum_w;
  logic [29:0]      p_w;
  logic [31:0]      rnd_w;
  logic [16:0]      pw_w;
  logic [16:0]      mq_w;
  logic [16:0]      onem_w;
  logic [IDX_W:0]   rem_sh;
  logic             div_ge;
  logic [IDX_W-1:0] n_w;
  rgba_t            mean_w;
  logic [17:0]      ca_sum_w;

  function automatic logic [16:0] sat17(input logic [16:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  function automatic logic [16:0] sat18(input logic [17:0] v);
    return (v > 18'(ONE_Q16)) ? ONE_Q16 : v[16:0];
  endfunction

  function automatic logic [16:0] mean17(input logic [16:0] a, input logic [16:0] b);
    logic [17:0] s;
    s = {1'b0, a} + {1'b0, b} + 18'd1;
    return s[17:1];
  endfunction

  assign f_entry        = in_tdata[9:0];
  assign f_rgba.red     = in_tdata[26:10];
  assign f_rgba.green   = in_tdata[43:27];
  assign f_rgba.blue    = in_tdata[60:44];
  assign f_rgba.opacity = in_tdata[77:61];
  assign f_front        = in_tdata[87:78];
  assign f_back         = in_tdata[97:88];

  assign ld_rgba.red     = sat17(f_rgba.red);
  assign ld_rgba.green   = sat17(f_rgba.green);
  assign ld_rgba.blue    = sat17(f_rgba.blue);
  assign ld_rgba.opacity = sat17(f_rgba.opacity);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // loads beyond the table are dropped, query indices clamp to the last entry
  assign ld_ok   = CMP_W'(f_entry) < CMP_W'(TABLE_ENTRIES);
  assign ld_addr = IDX_W'(f_entry);
  assign fr_cl   = (CMP_W'(f_front) < CMP_W'(TABLE_ENTRIES)) ? IDX_W'(f_front)
                                                             : IDX_W'(TABLE_ENTRIES - 1);
  assign bk_cl   = (CMP_W'(f_back) < CMP_W'(TABLE_ENTRIES)) ? IDX_W'(f_back)
                                                            : IDX_W'(TABLE_ENTRIES - 1);
  assign d_w     = (fr_cl < bk_cl) ? (bk_cl - fr_cl) : (fr_cl - bk_cl);

  assign ram_we = in_acc && (in_tuser == FUNC_LOAD) && ld_ok;

  ptte_ram #(
    .WIDTH ($bits(rgba_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ld_addr),
    .wr_data (ld_rgba),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // next entry toward back
  assign n_w       = up_r ? (m_r + IDX_W'(1)) : (m_r - IDX_W'(1));
  assign ram_raddr = (state_r == S_FETCHN) ? n_w : m_r;

  assign mean_w.red     = mean17(cur_r.red, ram_rdata.red);
  assign mean_w.green   = mean17(cur_r.green, ram_rdata.green);
  assign mean_w.blue    = mean17(cur_r.blue, ram_rdata.blue);
  assign mean_w.opacity = mean17(cur_r.opacity, ram_rdata.opacity);

  // restoring divider step, one quotient bit a cycle
  assign rem_sh = {rem_r, div_r[DIV_W-1]};
  assign div_ge = rem_sh >= {1'b0, d_r};

  // pow: log via repeated squaring, exp via product of roots
  assign t_w = ONE_Q16 - smp_r.opacity;

  always_comb begin
    e_w = '0;
    for (int i = 0; i < 17; i++) begin
      if (t_w[i]) begin
        e_w = 5'(i);
      end
    end
  end

  assign sq_w   = mul_p[61:30];
  assign nl_w   = {5'd16 - e_r, 16'h0} - {5'd0, frac_r};
  assign psum_w = mul_p[53:0] + (54'd1 << 23);
  assign p_w    = psum_w[53:24];
  assign rnd_w  = {1'b0, y_r} + (32'd1 << (5'd13 + q_r));
  assign pw_w   = 17'(rnd_w >> (5'd14 + q_r));
  assign mq_w   = 17'((mul_p[33:0] + 34'd32768) >> 16);
  assign onem_w = ONE_Q16 - sat18(ca_r);
  assign ca_sum_w = ca_r + {1'b0, acc_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LOG: begin
        mul_a = {1'b0, x_r};
        mul_b = {1'b0, x_r};
      end
      S_PMUL: begin
        mul_a = f_r;
        mul_b = {11'd0, nl_w};
      end
      S_EXP: begin
        mul_a = {1'b0, y_r};
        mul_b = {1'b0, ROOT_TAB[5'(cnt_r[3:0]) + 5'd1]};
      end
      S_ACC: begin
        mul_a = {15'd0, onem_w};
        mul_b = {15'd0, a_r};
      end
      S_CR: begin
        mul_a = {15'd0, acc_r};
        mul_b = {15'd0, smp_r.red};
      end
      S_CG: begin
        mul_a = {15'd0, acc_r};
        mul_b = {15'd0, smp_r.green};
      end
      S_CB: begin
        mul_a = {15'd0, acc_r};
        mul_b = {15'd0, smp_r.blue};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    step_ratio_nxt    = step_ratio_r;
    midpoint_mode_nxt = midpoint_mode_r;
    f_nxt    = f_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    d_nxt    = d_r;
    m_nxt    = m_r;
    bk_nxt   = bk_r;
    up_nxt   = up_r;
    eq_nxt   = eq_r;
    cur_nxt  = cur_r;
    smp_nxt  = smp_r;
    x_nxt    = x_r;
    frac_nxt = frac_r;
    e_nxt    = e_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    y_nxt    = y_r;
    a_nxt    = a_r;
    acc_nxt  = acc_r;
    cr_nxt   = cr_r;
    cg_nxt   = cg_r;
    cb_nxt   = cb_r;
    ca_nxt   = ca_r;
    out_nxt  = out_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_RATIO:    step_ratio_nxt    = cfg_data;
        REG_MIDPOINT_MODE: midpoint_mode_nxt = cfg_data[0];
        default:           step_ratio_nxt    = step_ratio_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == FUNC_QUERY)) begin
          m_nxt   = fr_cl;
          bk_nxt  = bk_cl;
          up_nxt  = fr_cl < bk_cl;
          eq_nxt  = fr_cl == bk_cl;
          d_nxt   = d_w;
          cr_nxt  = '0;
          cg_nxt  = '0;
          cb_nxt  = '0;
          ca_nxt  = '0;
          cnt_nxt = '0;
          rem_nxt = '0;
          f_nxt   = {step_ratio_r, 8'h0};
          div_nxt = {1'b0, step_ratio_r, 8'h0} + DIV_W'(d_w >> 1);
          state_nxt = (fr_cl == bk_cl) ? S_FETCH0 : S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = div_ge ? IDX_W'(rem_sh - {1'b0, d_r}) : IDX_W'(rem_sh);
        div_nxt = {div_r[DIV_W-2:0], div_ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_W - 1)) begin
          f_nxt     = div_nxt[31:0];
          state_nxt = S_FETCH0;
        end
      end
      S_FETCH0: begin
        state_nxt = S_FETCH0W;
      end
      S_FETCH0W: begin
        cur_nxt = ram_rdata;
        if (eq_r) begin
          smp_nxt   = ram_rdata;
          state_nxt = S_LOG_INIT;
        end else begin
          state_nxt = S_FETCHN;
        end
      end
      S_FETCHN: begin
        state_nxt = S_FETCHNW;
      end
      S_FETCHNW: begin
        smp_nxt   = midpoint_mode_r ? mean_w : cur_r;
        cur_nxt   = ram_rdata;
        m_nxt     = n_w;
        state_nxt = S_LOG_INIT;
      end
      S_LOG_INIT: begin
        // zero base: full opacity unless the exponent is zero
        if (t_w == '0) begin
          a_nxt     = (f_r == '0) ? '0 : ONE_Q16;
          state_nxt = S_ACC;
        end else begin
          e_nxt     = e_w;
          x_nxt     = {14'd0, t_w} << (5'd30 - e_w);
          frac_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_LOG;
        end
      end
      S_LOG: begin
        frac_nxt = {frac_r[14:0], sq_w[31]};
        x_nxt    = sq_w[31] ? sq_w[31:1] : sq_w[30:0];
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'd15) begin
          state_nxt = S_PMUL;
        end
      end
      S_PMUL: begin
        // exponent too large: power underflows to zero
        if (p_w[29:16] > 14'd16) begin
          a_nxt     = ONE_Q16;
          state_nxt = S_ACC;
        end else begin
          q_nxt     = p_w[20:16];
          r_nxt     = p_w[15:0];
          y_nxt     = 31'd1 << 30;
          cnt_nxt   = '0;
          state_nxt = S_EXP;
        end
      end
      S_EXP: begin
        if (r_r[15]) begin
          y_nxt = mul_p[60:30];
        end
        r_nxt   = {r_r[14:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd15) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        a_nxt     = ONE_Q16 - pw_w;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt   = mq_w;
        state_nxt = S_CR;
      end
      S_CR: begin
        cr_nxt    = cr_r + {1'b0, mq_w};
        state_nxt = S_CG;
      end
      S_CG: begin
        cg_nxt    = cg_r + {1'b0, mq_w};
        state_nxt = S_CB;
      end
      S_CB: begin
        cb_nxt    = cb_r + {1'b0, mq_w};
        ca_nxt    = ca_sum_w;
        state_nxt = (eq_r || (m_r == bk_r)) ? S_OUT : S_FETCHN;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_nxt.red     = sat18(cr_r);
          out_nxt.green   = sat18(cg_r);
          out_nxt.blue    = sat18(cb_r);
          out_nxt.opacity = sat18(ca_r);
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      step_ratio_r    <= 24'd6554;
      midpoint_mode_r <= 1'b1;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      step_ratio_r    <= step_ratio_nxt;
      midpoint_mode_r <= midpoint_mode_nxt;
      out_valid_r     <= out_valid_nxt;
    end
    f_r    <= f_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    d_r    <= d_nxt;
    m_r    <= m_nxt;
    bk_r   <= bk_nxt;
    up_r   <= up_nxt;
    eq_r   <= eq_nxt;
    cur_r  <= cur_nxt;
    smp_r  <= smp_nxt;
    x_r    <= x_nxt;
    frac_r <= frac_nxt;
    e_r    <= e_nxt;
    q_r    <= q_nxt;
    r_r    <= r_nxt;
    y_r    <= y_nxt;
    a_r    <= a_nxt;
    acc_r  <= acc_nxt;
    cr_r   <= cr_nxt;
    cg_r   <= cg_nxt;
    cb_r   <= cb_nxt;
    ca_r   <= ca_nxt;
    out_r  <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r};

  // a query request blocks further requests on the next cycle
  `ASSERT_NEXT(a_query_busy, clk, rst_n, in_acc && (in_tuser == FUNC_QUERY), !in_tready)
  // divider never runs with a zero distance
  `ASSERT_ALWAYS(a_div_nonzero, clk, rst_n, (state_r != S_DIV) || (d_r != '0))
  // accumulated opacity cannot pass one after front-to-back blending
  `ASSERT_ALWAYS(a_ca_bound, clk, rst_n, (state_r == S_IDLE) || (ca_r <= 18'(ONE_Q16)))

endmodule
